// File: hw/rtl/srsw_pkg.sv
// shared types and constants for the selective repeat send window
package srsw_pkg;

  typedef enum logic [2:0] {
    OP_ADD  = 3'd0,
    OP_ACK  = 3'd1,
    OP_ADV  = 3'd2,
    OP_DROP = 3'd3,
    OP_RST  = 3'd4,
    OP_LKP  = 3'd5,
    OP_TICK = 3'd6,
    OP_NOP  = 3'd7
  } op_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_NOTFND  = 2'd2,
    ST_TIMEOUT = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_EV,
    S_HRD,
    S_HEV,
    S_EMIT
  } state_e;

  localparam logic CFG_WINDOW_SIZE = 1'b0;
  localparam logic CFG_TIMEOUT     = 1'b1;

  localparam logic [4:0]  WINDOW_RST  = 5'd16;
  localparam logic [15:0] TIMEOUT_RST = 16'd100;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [31:0] seq_num;
    logic [4:0]  drop_count;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] seq_out;
    logic [4:0]  advance_count;
    logic [4:0]  occupancy;
    logic [31:0] head_seq;
    logic        last;
  } out_item_t;

  typedef struct packed {
    op_e         op;
    logic [31:0] seq;
    logic [4:0]  dcount;
  } cmd_t;

  typedef struct packed {
    logic vld;
    cmd_t cmd;
  } cmdq_t;

endpackage

// File: hw/rtl/srsw_front.sv
// front end: input transfer, opcode classification and two-entry command queue
module srsw_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  srsw_pkg::in_item_t  in_item_i,
  output srsw_pkg::cmdq_t     cmdq_o,
  input  logic                cmd_pop_i
);

  srsw_pkg::cmd_t fifo_q [2];
  logic           wr_ptr_q, rd_ptr_q;
  logic [1:0]     cnt_q;
  logic           push;
  srsw_pkg::cmd_t cmd_new;

  always_comb begin
    cmd_new.op     = srsw_pkg::op_e'(in_item_i.opcode);
    cmd_new.seq    = in_item_i.seq_num;
    cmd_new.dcount = in_item_i.drop_count;
  end

  assign in_ready_o = (cnt_q != 2'd2);
  assign push       = in_valid_i && in_ready_o;
  assign cmdq_o.vld = (cnt_q != 2'd0);
  assign cmdq_o.cmd = fifo_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (cmd_pop_i) rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + 2'(push) - 2'(cmd_pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) fifo_q[wr_ptr_q] <= cmd_new;
  end

endmodule

// File: hw/rtl/srsw_back.sv
// back end: window ring, scan sequencer and output register
module srsw_back #(
  parameter int WINDOW_DEPTH = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  srsw_pkg::cmdq_t      cmdq_i,
  output logic                 cmd_pop_o,
  input  logic [4:0]           window_size_i,
  input  logic [15:0]          timeout_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output srsw_pkg::out_item_t  out_item_o
);

  localparam int IW = $clog2(WINDOW_DEPTH);
  localparam int CW = $clog2(WINDOW_DEPTH + 1);
  localparam int KW = ((CW > 5) ? CW : 5) + 1;

  function automatic logic [IW-1:0] slot_f(input logic [IW-1:0] h, input logic [CW-1:0] off);
    logic [CW:0] s;
    s = (CW+1)'(h) + (CW+1)'(off);
    if (s >= (CW+1)'(WINDOW_DEPTH)) s = s - (CW+1)'(WINDOW_DEPTH);
    return s[IW-1:0];
  endfunction

  // ring storage
  logic [31:0] seq_mem  [WINDOW_DEPTH];
  logic [31:0] time_mem [WINDOW_DEPTH];
  logic        ack_mem  [WINDOW_DEPTH];
  logic [31:0] seq_rd_q, time_rd_q;
  logic        ack_rd_q;

  logic          rd_en;
  logic [IW-1:0] rd_addr;
  logic          we_seq, we_ack, we_time;
  logic [IW-1:0] wr_addr;
  logic          wr_ack;
  logic [31:0]   wr_seq;

  srsw_pkg::state_e state_q, state_d;
  srsw_pkg::cmd_t   cmd_q, cmd_d;
  logic [CW-1:0]    idx_q, idx_d, count_q, count_d, adv_q, adv_d;
  logic [IW-1:0]    head_q, head_d, addr_q, addr_d;
  logic [31:0]      now_q, now_d, head_seq_q, head_seq_d, prev_seq_q, prev_seq_d;
  logic [1:0]       status_q, status_d;
  logic             found_q, found_d, prev_q, prev_d;

  logic                out_valid_q, out_load, out_free;
  srsw_pkg::out_item_t out_item_q, out_d;

  logic [KW-1:0] cap, drop_n;
  logic          match, timed;
  logic [31:0]   age;

  assign out_free = !out_valid_q || out_ready_i;
  assign cap = (KW'(window_size_i) > KW'(WINDOW_DEPTH)) ? KW'(WINDOW_DEPTH)
                                                        : KW'(window_size_i);
  assign drop_n = (KW'(cmdq_i.cmd.dcount) < KW'(count_q)) ? KW'(cmdq_i.cmd.dcount)
                                                         : KW'(count_q);
  assign match = (seq_rd_q == cmd_q.seq);
  assign age   = now_q - time_rd_q;
  assign timed = !ack_rd_q && (age >= {16'd0, timeout_i});

  always_comb begin
    state_d    = state_q;
    cmd_d      = cmd_q;
    idx_d      = idx_q;
    count_d    = count_q;
    adv_d      = adv_q;
    head_d     = head_q;
    addr_d     = addr_q;
    now_d      = now_q;
    head_seq_d = head_seq_q;
    prev_seq_d = prev_seq_q;
    status_d   = status_q;
    found_d    = found_q;
    prev_d     = prev_q;
    cmd_pop_o  = 1'b0;
    rd_en      = 1'b0;
    rd_addr    = head_q;
    we_seq     = 1'b0;
    we_ack     = 1'b0;
    we_time    = 1'b0;
    wr_addr    = addr_q;
    wr_ack     = 1'b0;
    wr_seq     = cmd_q.seq;
    out_load   = 1'b0;
    out_d.status        = srsw_pkg::ST_OK;
    out_d.seq_out       = 32'd0;
    out_d.advance_count = 5'(adv_q);
    out_d.occupancy     = 5'(count_q);
    out_d.head_seq      = (count_q == '0) ? 32'd0 : head_seq_q;
    out_d.last          = 1'b1;

    case (state_q)
      srsw_pkg::S_IDLE: begin
        if (cmdq_i.vld) begin
          cmd_pop_o = 1'b1;
          cmd_d     = cmdq_i.cmd;
          idx_d     = '0;
          adv_d     = '0;
          status_d  = srsw_pkg::ST_OK;
          found_d   = 1'b0;
          prev_d    = 1'b0;
          case (cmdq_i.cmd.op)
            srsw_pkg::OP_ADD: begin
              if (KW'(count_q) >= cap) begin
                status_d = srsw_pkg::ST_FULL;
              end else begin
                wr_addr = slot_f(head_q, count_q);
                wr_seq  = cmdq_i.cmd.seq;
                we_seq  = 1'b1;
                we_ack  = 1'b1;
                we_time = 1'b1;
                if (count_q == '0) head_seq_d = cmdq_i.cmd.seq;
                count_d = count_q + CW'(1);
              end
              state_d = srsw_pkg::S_EMIT;
            end
            srsw_pkg::OP_DROP: begin
              adv_d   = CW'(drop_n);
              head_d  = slot_f(head_q, CW'(drop_n));
              count_d = count_q - CW'(drop_n);
              state_d = srsw_pkg::S_HRD;
            end
            srsw_pkg::OP_TICK: begin
              now_d   = now_q + 32'd1;
              state_d = srsw_pkg::S_RD;
            end
            srsw_pkg::OP_ACK, srsw_pkg::OP_ADV, srsw_pkg::OP_RST, srsw_pkg::OP_LKP: begin
              state_d = srsw_pkg::S_RD;
            end
            default: state_d = srsw_pkg::S_EMIT;
          endcase
        end
      end
      srsw_pkg::S_RD: begin
        if (idx_q >= count_q) begin
          state_d = (cmd_q.op == srsw_pkg::OP_ADV) ? srsw_pkg::S_HRD : srsw_pkg::S_EMIT;
        end else begin
          rd_en   = 1'b1;
          rd_addr = slot_f(head_q, idx_q);
          addr_d  = rd_addr;
          state_d = srsw_pkg::S_EV;
        end
      end
      srsw_pkg::S_EV: begin
        state_d = srsw_pkg::S_RD;
        idx_d   = idx_q + CW'(1);
        case (cmd_q.op)
          srsw_pkg::OP_ACK: begin
            if (match) begin
              we_ack  = 1'b1;
              wr_ack  = 1'b1;
              found_d = 1'b1;
              state_d = srsw_pkg::S_EMIT;
            end
          end
          srsw_pkg::OP_RST: begin
            if (match) begin
              we_time = 1'b1;
              found_d = 1'b1;
            end
          end
          srsw_pkg::OP_LKP: begin
            if (match) found_d = 1'b1;
          end
          srsw_pkg::OP_ADV: begin
            idx_d = idx_q;
            if (ack_rd_q) begin
              head_d  = slot_f(head_q, CW'(1));
              count_d = count_q - CW'(1);
              adv_d   = adv_q + CW'(1);
            end else begin
              state_d = srsw_pkg::S_HRD;
            end
          end
          srsw_pkg::OP_TICK: begin
            if (timed) begin
              if (prev_q) begin
                // report the earlier timeout before keeping this one
                if (out_free) begin
                  out_load      = 1'b1;
                  out_d.status  = srsw_pkg::ST_TIMEOUT;
                  out_d.seq_out = prev_seq_q;
                  out_d.last    = 1'b0;
                  prev_seq_d    = seq_rd_q;
                end else begin
                  idx_d   = idx_q;
                  state_d = srsw_pkg::S_EV;
                end
              end else begin
                prev_d     = 1'b1;
                prev_seq_d = seq_rd_q;
              end
            end
          end
          default: state_d = srsw_pkg::S_EMIT;
        endcase
      end
      srsw_pkg::S_HRD: begin
        if (count_q == '0) begin
          head_seq_d = 32'd0;
          state_d    = srsw_pkg::S_EMIT;
        end else begin
          rd_en   = 1'b1;
          rd_addr = head_q;
          state_d = srsw_pkg::S_HEV;
        end
      end
      srsw_pkg::S_HEV: begin
        head_seq_d = seq_rd_q;
        state_d    = srsw_pkg::S_EMIT;
      end
      srsw_pkg::S_EMIT: begin
        case (cmd_q.op)
          srsw_pkg::OP_ADD: out_d.status = status_q;
          srsw_pkg::OP_ACK, srsw_pkg::OP_RST, srsw_pkg::OP_LKP:
            out_d.status = found_q ? srsw_pkg::ST_OK : srsw_pkg::ST_NOTFND;
          srsw_pkg::OP_TICK: begin
            if (prev_q) begin
              out_d.status  = srsw_pkg::ST_TIMEOUT;
              out_d.seq_out = prev_seq_q;
            end
          end
          default: out_d.status = srsw_pkg::ST_OK;
        endcase
        if (out_free) begin
          out_load = 1'b1;
          state_d  = srsw_pkg::S_IDLE;
        end
      end
      default: state_d = srsw_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= srsw_pkg::S_IDLE;
      idx_q       <= '0;
      count_q     <= '0;
      adv_q       <= '0;
      head_q      <= '0;
      now_q       <= 32'd0;
      head_seq_q  <= 32'd0;
      status_q    <= srsw_pkg::ST_OK;
      found_q     <= 1'b0;
      prev_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      idx_q      <= idx_d;
      count_q    <= count_d;
      adv_q      <= adv_d;
      head_q     <= head_d;
      now_q      <= now_d;
      head_seq_q <= head_seq_d;
      status_q   <= status_d;
      found_q    <= found_d;
      prev_q     <= prev_d;
      if (out_load) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    addr_q     <= addr_d;
    prev_seq_q <= prev_seq_d;
    if (out_load) out_item_q <= out_d;
  end

  // ring memories: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_seq) seq_mem[wr_addr] <= wr_seq;
    if (we_ack) ack_mem[wr_addr] <= wr_ack;
    if (we_time) time_mem[wr_addr] <= now_q;
    if (rd_en) begin
      seq_rd_q  <= seq_mem[rd_addr];
      ack_rd_q  <= ack_mem[rd_addr];
      time_rd_q <= time_mem[rd_addr];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

// File: hw/rtl/selective_repeat_send_window_top.sv
// top level of the selective repeat send window
//
//  channel | direction | handshake                 | payload
//  in      | input     | in_valid_i / in_ready_o   | in_item_i  (opcode, seq_num, drop_count)
//  out     | output    | out_valid_o / out_ready_i | out_item_o (status ... last)
//  cfg     | input     | cfg_we_i                  | cfg_idx_i, cfg_wdata_i
//
// one command at a time: add and unused codes go from idle straight to emit, drop
// rereads the head entry unless the window is left empty, scanning operations read
// then check each entry visited through the single read port of the window ring
// advance reads and checks each entry it pops, then rereads the head entry
// a two-entry command queue takes transfers while the back end is busy
// output register stalls hold the scan; reset covers control and config registers, not data
module selective_repeat_send_window_top #(
  parameter int WINDOW_DEPTH = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  srsw_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output srsw_pkg::out_item_t out_item_o,
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [15:0]         cfg_wdata_i
);

  srsw_pkg::cmdq_t cmdq;
  logic            cmd_pop;
  logic [4:0]      window_q;
  logic [15:0]     timeout_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q  <= srsw_pkg::WINDOW_RST;
      timeout_q <= srsw_pkg::TIMEOUT_RST;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == srsw_pkg::CFG_WINDOW_SIZE) window_q <= cfg_wdata_i[4:0];
      if (cfg_idx_i == srsw_pkg::CFG_TIMEOUT) timeout_q <= cfg_wdata_i;
    end
  end

  // front: transfer in and queue the classified command
  srsw_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .cmdq_o     (cmdq),
    .cmd_pop_i  (cmd_pop)
  );

  // back: walk the window and produce results
  srsw_back #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmdq_i        (cmdq),
    .cmd_pop_o     (cmd_pop),
    .window_size_i (window_q),
    .timeout_i     (timeout_q),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_item_o    (out_item_o)
  );

endmodule

// File: hw/rtl/srsw_checker.sv
// port-level checks for the selective repeat send window
module srsw_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input srsw_pkg::out_item_t out_item_o
);

  // held result stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("result changed while stalled");

  // only timeout reports may be followed by more results
  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.last |-> out_item_o.status == srsw_pkg::ST_TIMEOUT)
    else $error("non-final result that is not a timeout");

  a_seq_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.status != srsw_pkg::ST_TIMEOUT |-> out_item_o.seq_out == 32'd0)
    else $error("sequence out set on a non-timeout result");

  a_empty_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.occupancy == 5'd0 |-> out_item_o.head_seq == 32'd0)
    else $error("head sequence set on empty window");

  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.status == srsw_pkg::ST_FULL |->
      out_item_o.advance_count == 5'd0 && out_item_o.last)
    else $error("bad window full result");

endmodule

bind selective_repeat_send_window_top srsw_checker u_srsw_checker (.*);
